// ----- sv/sdc_pkg.sv -----
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types, constants and small helpers of the sun direction block.
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam int DAY_FRAC_BITS_DEF = 32;
  localparam int CORDIC_ITER_DEF   = 18;
  localparam int VW                = 36;

  typedef logic signed [VW-1:0]   val_t;
  typedef logic signed [2*VW-1:0] prod_t;

  localparam val_t PI_Q30       = 36'sd3373259426;
  localparam val_t HALF_PI_Q30  = 36'sd1686629713;
  localparam val_t GAIN_INV_Q30 = 36'sd652032874;
  localparam val_t ONE_Q30      = 36'sd1073741824;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [2:0] REG_DAY_LENGTH  = 3'd0;
  localparam logic [2:0] REG_YEAR_LENGTH = 3'd1;
  localparam logic [2:0] REG_DAY_START   = 3'd2;
  localparam logic [2:0] REG_YEAR_START  = 3'd3;
  localparam logic [2:0] REG_OBLIQUITY   = 3'd4;
  localparam logic [2:0] REG_LATITUDE    = 3'd5;
  localparam logic [2:0] REG_ELEV_START  = 3'd6;
  localparam logic [2:0] REG_ELEV_END    = 3'd7;

  function automatic val_t atan_q30(input logic [4:0] i);
    val_t r;
    case (i)
      5'd0:  r = 36'sd843314857;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043837;
      5'd3:  r = 36'sd133525159;
      5'd4:  r = 36'sd67021687;
      5'd5:  r = 36'sd33543516;
      5'd6:  r = 36'sd16775851;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194283;
      5'd9:  r = 36'sd2097149;
      5'd10: r = 36'sd1048576;
      5'd11: r = 36'sd524288;
      5'd12: r = 36'sd262144;
      5'd13: r = 36'sd131072;
      5'd14: r = 36'sd65536;
      5'd15: r = 36'sd32768;
      5'd16: r = 36'sd16384;
      5'd17: r = 36'sd8192;
      5'd18: r = 36'sd4096;
      5'd19: r = 36'sd2048;
      5'd20: r = 36'sd1024;
      5'd21: r = 36'sd512;
      5'd22: r = 36'sd256;
      5'd23: r = 36'sd128;
      5'd24: r = 36'sd64;
      5'd25: r = 36'sd32;
      5'd26: r = 36'sd16;
      5'd27: r = 36'sd8;
      5'd28: r = 36'sd4;
      5'd29: r = 36'sd2;
      5'd30: r = 36'sd1;
      default: r = 36'sd0;
    endcase
    return r;
  endfunction

  // Signed Q1.15 from a magnitude quotient, saturated
  function automatic logic signed [15:0] q15_sat(input logic neg, input logic [63:0] q);
    logic [15:0] r;
    r = q[15:0];
    if (neg) begin
      return (q > 64'd32768) ? 16'sh8000 : 16'(-r);
    end
    return (q > 64'd32767) ? 16'sh7FFF : r;
  endfunction

  // Signed Q8.16 from a magnitude quotient, saturated
  function automatic logic signed [23:0] coord_sat(input logic neg, input logic [63:0] q);
    logic [23:0] r;
    r = q[23:0];
    if (neg) begin
      return (q > 64'd8388608) ? 24'sh800000 : 24'(-r);
    end
    return (q > 64'd8388607) ? 24'sh7FFFFF : r;
  endfunction

endpackage

// ----- sv/sun_direction_from_clock_top.sv -----
// ----------------------------------------------------------------------------
// sun_direction_from_clock_top
// Simulated clock and sun direction: day position, hour angle, declination,
// elevation/azimuth and a normalised direction word.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word per tick. opcode 0 advances the
// day position by elapsed_seconds / day_length, opcode 1 restarts it at the
// configured start. Each input word yields exactly one output word
// (out_valid/out_ready) with the Q1.15 direction and the spectrum coordinate.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready; the user
// must write it only while the block is idle; the block itself does not enforce this.
// Each word takes up to seven passes through the shared radix-2 divider, three
// through the square root unit, four CORDIC runs and sixteen multiplies.
// Degenerate vectors skip divider passes.
// in_ready is high only while the sequencer is idle. The result sits in an
// output register; a stalled receiver does not stop the next word being
// taken, but the sequencer holds before writing a new result until the old one
// is taken. Reset (synchronous) restores the register defaults, clears the day
// position and drops any word in flight.
// ----------------------------------------------------------------------------
module sun_direction_from_clock_top import sdc_pkg::*; #(
  parameter int DAY_FRAC_BITS     = DAY_FRAC_BITS_DEF,
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [31:0]        in_elapsed_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [15:0] out_dir_z,
  output logic signed [23:0] out_spectrum_coord,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int F    = DAY_FRAC_BITS;
  localparam int SH_R = (F >= 32) ? F - 32 : 0;
  localparam int SH_L = (F >= 32) ? 0 : 32 - F;
  localparam int CIW  = $clog2(CORDIC_ITERATIONS);
  localparam logic [CIW-1:0] CI_LAST = CIW'(CORDIC_ITERATIONS - 1);
  localparam logic [63:0] FRAC_MASK = (64'd1 << F) - 64'd1;
  localparam logic [63:0] POS_MASK  = (64'd1 << 48) - 64'd1;
  localparam logic [63:0] ONE_SQ    = 64'd1 << 60;
  localparam logic [6:0]  DIV_STEPS = 7'd64;
  localparam logic [5:0]  SQ_STEPS  = 6'd32;

  localparam logic [5:0] ST_IDLE  = 6'd0;
  localparam logic [5:0] ST_PDIV  = 6'd1;
  localparam logic [5:0] ST_PADD  = 6'd2;
  localparam logic [5:0] ST_PWRAP = 6'd3;
  localparam logic [5:0] ST_HMUL  = 6'd4;
  localparam logic [5:0] ST_HCOR  = 6'd5;
  localparam logic [5:0] ST_YDIV  = 6'd6;
  localparam logic [5:0] ST_YMUL  = 6'd7;
  localparam logic [5:0] ST_YCOR  = 6'd8;
  localparam logic [5:0] ST_DMUL  = 6'd9;
  localparam logic [5:0] ST_DCOR  = 6'd10;
  localparam logic [5:0] ST_LCOR  = 6'd11;
  localparam logic [5:0] ST_M1    = 6'd12;
  localparam logic [5:0] ST_M2    = 6'd13;
  localparam logic [5:0] ST_M3    = 6'd14;
  localparam logic [5:0] ST_M4    = 6'd15;
  localparam logic [5:0] ST_M5    = 6'd16;
  localparam logic [5:0] ST_M6    = 6'd17;
  localparam logic [5:0] ST_M7    = 6'd18;
  localparam logic [5:0] ST_SQE   = 6'd19;
  localparam logic [5:0] ST_CADIV = 6'd20;
  localparam logic [5:0] ST_M8    = 6'd21;
  localparam logic [5:0] ST_SQA   = 6'd22;
  localparam logic [5:0] ST_M9    = 6'd23;
  localparam logic [5:0] ST_M10   = 6'd24;
  localparam logic [5:0] ST_M11   = 6'd25;
  localparam logic [5:0] ST_M12   = 6'd26;
  localparam logic [5:0] ST_M13   = 6'd27;
  localparam logic [5:0] ST_SQL   = 6'd28;
  localparam logic [5:0] ST_QX    = 6'd29;
  localparam logic [5:0] ST_QY    = 6'd30;
  localparam logic [5:0] ST_QZ    = 6'd31;
  localparam logic [5:0] ST_SDIV  = 6'd32;
  localparam logic [5:0] ST_OUT   = 6'd33;

  // configuration
  logic [23:0]        day_length_r, day_start_r;
  logic [15:0]        year_length_r, year_start_r;
  logic signed [17:0] obliquity_r, latitude_r;
  logic signed [15:0] elev_start_r, elev_end_r;

  // sequencer and working registers
  logic [5:0]         state_r;
  logic               ph_r;
  logic               op_r;
  logic [31:0]        es_r;
  logic [47:0]        pos_r;
  logic [63:0]        tmp_r, acc_r;
  logic               after_noon_r;
  val_t               ch_r, cos_y_r, sd_r, cd_r, sp_r, cp_r, t1_r, t2_r;
  val_t               sin_e_r, num_r, cos_e_r, cos_a_r, sin_a_r, vx_r, vz_r;
  logic [31:0]        len_r;
  logic signed [15:0] dx_r, dy_r, dz_r;
  logic signed [23:0] sc_r;
  logic               out_valid_r;
  logic signed [15:0] out_x_r, out_y_r, out_z_r;
  logic signed [23:0] out_sc_r;

  // shared multiplier
  val_t  mul_a, mul_b, m30, p31, p16;
  prod_t prod_r;

  // divider
  logic        div_start;
  logic [63:0] div_num, div_q_r;
  logic [31:0] div_den, div_d_r, div_rem_r;
  logic [6:0]  div_cnt_r;
  logic [32:0] div_t, div_sub;
  logic        div_ge;

  // square root
  logic        sq_start;
  logic [63:0] sq_in, sq_v_r;
  logic [33:0] sq_rem_r;
  logic [31:0] sq_root_r;
  logic [5:0]  sq_cnt_r;
  logic [35:0] sq_t, sq_trial, sq_diff;
  logic        sq_ge;
  val_t        sq_root_v;

  // CORDIC
  logic           cor_start, cor_hi, cor_lo;
  val_t           cor_in, cor_fold, cx_r, cy_r, ca_r, cor_s, cor_c, cor_atan;
  logic           cflip_r, crun_r;
  logic [CIW-1:0] ci_r;

  // misc datapath
  logic [23:0]        dl;
  logic [15:0]        yl;
  logic [63:0]        pos_sum, lim, pos_wrap, pos_frac, turn_h64, turn_y64;
  logic [47:0]        pos_nxt;
  logic [31:0]        turn_h, hturn, turn_y;
  val_t               lat_ext, sin_e_sum, sin_e_nxt, qv;
  logic [VW-1:0]      num_mag, cose_u, qmag;
  logic signed [16:0] snum, sden;
  logic [16:0]        snum_mag, sden_mag;
  logic               sc_neg;
  logic signed [23:0] sc_special;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_dir_x = out_x_r;
  assign out_dir_y = out_y_r;
  assign out_dir_z = out_z_r;
  assign out_spectrum_coord = out_sc_r;

  assign dl = (day_length_r == 24'd0) ? 24'd1 : day_length_r;
  assign yl = (year_length_r == 16'd0) ? 16'd1 : year_length_r;

  // day position update
  assign pos_sum = (op_r == OP_RESTART)
                 ? ((div_q_r + (64'(year_start_r) << F)) & POS_MASK)
                 : (64'(pos_r) + div_q_r);
  assign lim      = 64'(yl) << F;
  assign pos_wrap = (tmp_r >= lim) ? tmp_r - lim : tmp_r;
  assign pos_nxt  = pos_wrap[47:0];

  // turn phases
  assign pos_frac = 64'(pos_r) & FRAC_MASK;
  assign turn_h64 = (pos_frac >> SH_R) << SH_L;
  assign turn_h   = turn_h64[31:0];
  assign hturn    = {~turn_h[31], turn_h[30:0]};
  assign turn_y64 = (div_q_r >> SH_R) << SH_L;
  assign turn_y   = turn_y64[31:0];

  assign m30 = prod_r[65:30];
  assign p31 = prod_r[66:31];
  assign p16 = prod_r[51:16];
  assign lat_ext = {{(VW-18){latitude_r[17]}}, latitude_r};

  assign sin_e_sum = t1_r + m30;
  assign sin_e_nxt = (sin_e_sum > ONE_Q30) ? ONE_Q30 :
                     (sin_e_sum < -ONE_Q30) ? -ONE_Q30 : sin_e_sum;

  assign num_mag = num_r[VW-1] ? VW'(-num_r) : VW'(num_r);
  assign cose_u  = cos_e_r;

  always_comb begin
    unique case (state_r)
      ST_QY:   qv = sin_e_r;
      ST_QZ:   qv = vz_r;
      default: qv = vx_r;
    endcase
  end
  assign qmag = qv[VW-1] ? VW'(-qv) : VW'(qv);

  assign snum     = {dy_r[15], dy_r} - {elev_start_r[15], elev_start_r};
  assign sden     = {elev_end_r[15], elev_end_r} - {elev_start_r[15], elev_start_r};
  assign snum_mag = snum[16] ? 17'(-snum) : 17'(snum);
  assign sden_mag = sden[16] ? 17'(-sden) : 17'(sden);
  assign sc_neg   = snum[16] ^ sden[16];
  assign sc_special = (snum > 17'sd0) ? 24'sh7FFFFF :
                      (snum < 17'sd0) ? 24'sh800000 : 24'sd0;

  // multiplier operand select; product registered every cycle
  always_comb begin
    unique case (state_r)
      ST_HMUL: begin mul_a = {{(VW-32){hturn[31]}}, hturn};  mul_b = PI_Q30; end
      ST_YMUL: begin mul_a = {{(VW-32){turn_y[31]}}, turn_y}; mul_b = PI_Q30; end
      ST_DMUL: begin mul_a = {{(VW-18){obliquity_r[17]}}, obliquity_r}; mul_b = cos_y_r; end
      ST_M1:   begin mul_a = sd_r;    mul_b = sp_r;    end
      ST_M2:   begin mul_a = cd_r;    mul_b = cp_r;    end
      ST_M3:   begin mul_a = t2_r;    mul_b = ch_r;    end
      ST_M4:   begin mul_a = sd_r;    mul_b = cp_r;    end
      ST_M5:   begin mul_a = cd_r;    mul_b = sp_r;    end
      ST_M6:   begin mul_a = t2_r;    mul_b = ch_r;    end
      ST_M7:   begin mul_a = sin_e_r; mul_b = sin_e_r; end
      ST_M8:   begin mul_a = cos_a_r; mul_b = cos_a_r; end
      ST_M9:   begin mul_a = cos_e_r; mul_b = cos_a_r; end
      ST_M10:  begin mul_a = cos_e_r; mul_b = sin_a_r; end
      ST_M11:  begin mul_a = vx_r;    mul_b = vx_r;    end
      ST_M12:  begin mul_a = sin_e_r; mul_b = sin_e_r; end
      ST_M13:  begin mul_a = vz_r;    mul_b = vz_r;    end
      default: begin mul_a = '0;      mul_b = '0;      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // divider: restoring, one quotient bit a cycle
  assign div_start = !ph_r && ((state_r == ST_PDIV) || (state_r == ST_YDIV) ||
                     (state_r == ST_QY) || (state_r == ST_QZ) ||
                     ((state_r == ST_QX) && (len_r != 32'd0)) ||
                     ((state_r == ST_SDIV) && (sden != 17'sd0)) ||
                     ((state_r == ST_CADIV) && (cos_e_r != '0) && (num_mag < cose_u)));

  always_comb begin
    unique case (state_r)
      ST_PDIV: begin
        div_num = (op_r == OP_RESTART) ? (64'(day_start_r) << F)
                                       : (64'(es_r) << (F - 16));
        div_den = 32'(dl);
      end
      ST_YDIV: begin
        div_num = 64'(pos_r);
        div_den = 32'(yl);
      end
      ST_CADIV: begin
        div_num = 64'(num_mag) << 30;
        div_den = cose_u[31:0];
      end
      ST_SDIV: begin
        div_num = (64'(snum_mag) << 16) + 64'(sden_mag >> 1);
        div_den = 32'(sden_mag);
      end
      default: begin
        div_num = (64'(qmag) << 15) + 64'(len_r >> 1);
        div_den = len_r;
      end
    endcase
  end

  assign div_t   = {div_rem_r, div_q_r[63]};
  assign div_ge  = div_t >= {1'b0, div_d_r};
  assign div_sub = div_t - {1'b0, div_d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_start) begin
      div_q_r   <= div_num;
      div_d_r   <= div_den;
      div_rem_r <= '0;
      div_cnt_r <= DIV_STEPS;
    end else if (div_cnt_r != 7'd0) begin
      div_q_r   <= {div_q_r[62:0], div_ge};
      div_rem_r <= div_ge ? div_sub[31:0] : div_t[31:0];
      div_cnt_r <= div_cnt_r - 7'd1;
    end
  end

  // square root: two radicand bits a cycle
  assign sq_start = !ph_r && ((state_r == ST_SQE) || (state_r == ST_SQA) ||
                              (state_r == ST_SQL));
  assign sq_in    = (state_r == ST_SQL) ? acc_r + prod_r[63:0] : ONE_SQ - prod_r[63:0];
  assign sq_t     = {sq_rem_r, sq_v_r[63:62]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;
  assign sq_diff  = sq_t - sq_trial;
  assign sq_root_v = {{(VW-32){1'b0}}, sq_root_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r <= '0;
    end else if (sq_start) begin
      sq_v_r    <= sq_in;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_cnt_r  <= SQ_STEPS;
    end else if (sq_cnt_r != 6'd0) begin
      sq_v_r    <= sq_v_r << 2;
      sq_rem_r  <= sq_ge ? sq_diff[33:0] : sq_t[33:0];
      sq_root_r <= {sq_root_r[30:0], sq_ge};
      sq_cnt_r  <= sq_cnt_r - 6'd1;
    end
  end

  // CORDIC rotation, one micro-rotation a cycle
  assign cor_start = !ph_r && ((state_r == ST_HCOR) || (state_r == ST_YCOR) ||
                               (state_r == ST_DCOR) || (state_r == ST_LCOR));

  always_comb begin
    unique case (state_r)
      ST_DCOR: cor_in = -p16;
      ST_LCOR: cor_in = lat_ext <<< 14;
      default: cor_in = p31;
    endcase
  end

  assign cor_hi   = cor_in > HALF_PI_Q30;
  assign cor_lo   = cor_in < -HALF_PI_Q30;
  assign cor_fold = cor_hi ? cor_in - PI_Q30 : (cor_lo ? cor_in + PI_Q30 : cor_in);
  assign cor_atan = atan_q30(5'(ci_r));
  assign cor_s    = cflip_r ? -cy_r : cy_r;
  assign cor_c    = cflip_r ? -cx_r : cx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crun_r <= 1'b0;
    end else if (cor_start) begin
      cx_r    <= GAIN_INV_Q30;
      cy_r    <= '0;
      ca_r    <= cor_fold;
      cflip_r <= cor_hi | cor_lo;
      ci_r    <= '0;
      crun_r  <= 1'b1;
    end else if (crun_r) begin
      if (ca_r >= 0) begin
        cx_r <= cx_r - (cy_r >>> ci_r);
        cy_r <= cy_r + (cx_r >>> ci_r);
        ca_r <= ca_r - cor_atan;
      end else begin
        cx_r <= cx_r + (cy_r >>> ci_r);
        cy_r <= cy_r - (cx_r >>> ci_r);
        ca_r <= ca_r + cor_atan;
      end
      ci_r <= ci_r + 1'b1;
      if (ci_r == CI_LAST) begin
        crun_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_length_r  <= 24'd86400;
      year_length_r <= 16'd365;
      day_start_r   <= 24'd0;
      year_start_r  <= 16'd0;
      obliquity_r   <= 18'sd26795;
      latitude_r    <= 18'sd0;
      elev_start_r  <= 16'sd0;
      elev_end_r    <= 16'sd32767;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DAY_LENGTH:  day_length_r  <= cfg_data;
        REG_YEAR_LENGTH: year_length_r <= cfg_data[15:0];
        REG_DAY_START:   day_start_r   <= cfg_data;
        REG_YEAR_START:  year_start_r  <= cfg_data[15:0];
        REG_OBLIQUITY:   obliquity_r   <= cfg_data[17:0];
        REG_LATITUDE:    latitude_r    <= cfg_data[17:0];
        REG_ELEV_START:  elev_start_r  <= cfg_data[15:0];
        REG_ELEV_END:    elev_end_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      // ST_OUT handles the output register itself
      if (out_valid_r && out_ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r    <= in_opcode;
            es_r    <= in_elapsed_seconds;
            ph_r    <= 1'b0;
            state_r <= ST_PDIV;
          end
        end
        ST_PDIV, ST_YDIV: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else if (div_cnt_r == 7'd0) begin
            ph_r    <= 1'b0;
            state_r <= (state_r == ST_PDIV) ? ST_PADD : ST_YMUL;
          end
        end
        ST_PADD: begin
          tmp_r   <= pos_sum;
          state_r <= ST_PWRAP;
        end
        ST_PWRAP: begin
          pos_r   <= pos_nxt;
          state_r <= ST_HMUL;
        end
        ST_HMUL: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            after_noon_r <= (hturn != 32'd0) && !hturn[31];
            ph_r    <= 1'b0;
            state_r <= ST_HCOR;
          end
        end
        ST_YMUL, ST_DMUL: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            ph_r    <= 1'b0;
            state_r <= (state_r == ST_YMUL) ? ST_YCOR : ST_DCOR;
          end
        end
        ST_HCOR, ST_YCOR, ST_DCOR, ST_LCOR: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else if (!crun_r) begin
            ph_r <= 1'b0;
            unique case (state_r)
              ST_HCOR: begin ch_r <= cor_c; state_r <= ST_YDIV; end
              ST_YCOR: begin cos_y_r <= cor_c; state_r <= ST_DMUL; end
              ST_DCOR: begin sd_r <= cor_s; cd_r <= cor_c; state_r <= ST_LCOR; end
              default: begin sp_r <= cor_s; cp_r <= cor_c; state_r <= ST_M1; end
            endcase
          end
        end
        ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
        ST_M9, ST_M10, ST_M11, ST_M12, ST_M13: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            unique case (state_r)
              ST_M1:   begin t1_r <= m30; state_r <= ST_M2; end
              ST_M2:   begin t2_r <= m30; state_r <= ST_M3; end
              ST_M3:   begin sin_e_r <= sin_e_nxt; state_r <= ST_M4; end
              ST_M4:   begin t1_r <= m30; state_r <= ST_M5; end
              ST_M5:   begin t2_r <= m30; state_r <= ST_M6; end
              ST_M6:   begin num_r <= t1_r - m30; state_r <= ST_M7; end
              ST_M7:   state_r <= ST_SQE;
              ST_M8:   state_r <= ST_SQA;
              ST_M9:   begin vx_r <= m30; state_r <= ST_M10; end
              ST_M10:  begin vz_r <= m30; state_r <= ST_M11; end
              ST_M11:  begin acc_r <= prod_r[63:0]; state_r <= ST_M12; end
              ST_M12:  begin acc_r <= acc_r + prod_r[63:0]; state_r <= ST_M13; end
              default: state_r <= ST_SQL;
            endcase
          end
        end
        ST_SQE, ST_SQA, ST_SQL: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else if (sq_cnt_r == 6'd0) begin
            ph_r <= 1'b0;
            unique case (state_r)
              ST_SQE: begin cos_e_r <= sq_root_v; state_r <= ST_CADIV; end
              ST_SQA: begin
                sin_a_r <= after_noon_r ? -sq_root_v : sq_root_v;
                state_r <= ST_M9;
              end
              default: begin len_r <= sq_root_r; state_r <= ST_QX; end
            endcase
          end
        end
        ST_CADIV: begin
          if (!ph_r) begin
            if (cos_e_r == '0) begin
              cos_a_r <= ONE_Q30;
              state_r <= ST_M8;
            end else if (num_mag >= cose_u) begin
              cos_a_r <= num_r[VW-1] ? -ONE_Q30 : ONE_Q30;
              state_r <= ST_M8;
            end else begin
              ph_r <= 1'b1;
            end
          end else if (div_cnt_r == 7'd0) begin
            cos_a_r <= num_r[VW-1] ? -val_t'(div_q_r[VW-2:0]) : val_t'(div_q_r[VW-2:0]);
            ph_r    <= 1'b0;
            state_r <= ST_M8;
          end
        end
        ST_QX, ST_QY, ST_QZ: begin
          if (!ph_r) begin
            if ((state_r == ST_QX) && (len_r == 32'd0)) begin
              dx_r    <= '0;
              dy_r    <= '0;
              dz_r    <= '0;
              state_r <= ST_SDIV;
            end else begin
              ph_r <= 1'b1;
            end
          end else if (div_cnt_r == 7'd0) begin
            ph_r <= 1'b0;
            unique case (state_r)
              ST_QX:   begin dx_r <= q15_sat(qv[VW-1], div_q_r); state_r <= ST_QY; end
              ST_QY:   begin dy_r <= q15_sat(qv[VW-1], div_q_r); state_r <= ST_QZ; end
              default: begin dz_r <= q15_sat(qv[VW-1], div_q_r); state_r <= ST_SDIV; end
            endcase
          end
        end
        ST_SDIV: begin
          if (!ph_r) begin
            if (sden == 17'sd0) begin
              sc_r    <= sc_special;
              state_r <= ST_OUT;
            end else begin
              ph_r <= 1'b1;
            end
          end else if (div_cnt_r == 7'd0) begin
            sc_r    <= coord_sat(sc_neg, div_q_r);
            ph_r    <= 1'b0;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_x_r     <= dx_r;
            out_y_r     <= dy_r;
            out_z_r     <= dz_r;
            out_sc_r    <= sc_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          ph_r    <= 1'b0;
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
